// ===== hw/rtl/rar_pkg.sv =====
// rational arithmetic reducer: shared types and constants
// no dependencies
`default_nettype none
package rar_pkg;
  typedef enum logic [1:0] {
    OP_REDUCE = 2'd0,
    OP_SCALE  = 2'd1,
    OP_MUL    = 2'd2,
    OP_ADD    = 2'd3
  } op_t;
  localparam int unsigned OP_W = 2;
endpackage
`default_nettype wire

// ===== hw/rtl/rational_arithmetic_reducer_top.sv =====
// top level of the rational arithmetic reducer
// depends on rar_pkg, rar_front, rar_back (and rar_divider)
`default_nettype none
// Usage:
// Drive opcode and the two fractions on the in_ ports and raise start; the
// item transfers at a clock edge where start is high and busy is low.
// The front end registers the operands and then the wrapped products, forms
// the sums and places the pair in a one-entry queue; the back end pulls it
// and reduces it. The back end finds the gcd with Euclid's algorithm on a
// shared bit-serial divider, then divides numerator and denominator by it
// (two more divider runs). The number k of remainder steps is at most
// about 47 for 32-bit words, typically far fewer.
// One item is reduced at a time; the next item can be taken into the front
// end while the back end works.
// Each result appears for one cycle with out_valid high; the receiver
// cannot stall. zero_gcd_error marks a 0/0 input to the reduction.
// Synchronous reset clears all control state; no item is in flight after it.
module rational_arithmetic_reducer_top #(
  parameter int unsigned WORD_WIDTH = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [1:0]              in_opcode,
  input  wire logic [31:0]             in_a_numerator,
  input  wire logic [31:0]             in_a_denominator,
  input  wire logic [31:0]             in_b_numerator,
  input  wire logic [31:0]             in_b_denominator,
  output logic                         out_valid,
  output logic [31:0]                  out_result_numerator,
  output logic [31:0]                  out_result_denominator,
  output logic                         out_zero_gcd_error
);
  import rar_pkg::*;

  localparam int unsigned W = WORD_WIDTH;
  logic [W-1:0] an, ad, bn, bd, qn, qd, rn, rd;
  logic qv, qp;

  // mask or extend operands to the word width
  assign an = W'(in_a_numerator);
  assign ad = W'(in_a_denominator);
  assign bn = W'(in_b_numerator);
  assign bd = W'(in_b_denominator);

  rar_front #(.W(W)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(in_opcode),
    .an(an), .ad(ad), .bn(bn), .bd(bd),
    .q_valid(qv), .q_num(qn), .q_den(qd), .q_pop(qp)
  );

  rar_back #(.W(W)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(qv), .q_num(qn), .q_den(qd),
    .q_pop(qp), .out_valid(out_valid), .out_num(rn), .out_den(rd),
    .out_err(out_zero_gcd_error)
  );

  assign out_result_numerator = 32'(rn);
  assign out_result_denominator = 32'(rd);
endmodule
`default_nettype wire

// ===== hw/rtl/rar_front.sv =====
// front end: accepts items and forms the unreduced numerator and denominator
// depends on rar_pkg
`default_nettype none
module rar_front #(
  parameter int unsigned W = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [rar_pkg::OP_W-1:0] op,
  input  wire logic [W-1:0]          an,
  input  wire logic [W-1:0]          ad,
  input  wire logic [W-1:0]          bn,
  input  wire logic [W-1:0]          bd,
  output logic                       q_valid,
  output logic [W-1:0]               q_num,
  output logic [W-1:0]               q_den,
  input  wire logic                  q_pop
);
  import rar_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_SUM} st_t;
  st_t st_r;
  op_t op_r;
  logic [W-1:0] an_r, ad_r, bn_r, bd_r;
  logic [W-1:0] p0_r, p1_r;
  logic [W-1:0] m0, m1;
  logic [2*W-1:0] w0, w1;
  logic q_full_r;
  logic [W-1:0] qn_r, qd_r;

  // two products per cycle, kept to the word width
  assign w0 = (2*W)'(an_r) * (2*W)'((op_r == OP_ADD) ? bd_r : bn_r);
  assign w1 = (2*W)'(bn_r) * (2*W)'((op_r == OP_ADD) ? ad_r : bd_r);
  assign m0 = w0[W-1:0];
  assign m1 = w1[W-1:0];

  assign busy = (st_r != S_IDLE) || q_full_r;
  assign q_valid = q_full_r;
  assign q_num = qn_r;
  assign q_den = qd_r;

  // operand capture and one-entry queue toward the back end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      q_full_r <= 1'b0;
    end else begin
      if (q_pop) q_full_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (start && !busy) begin
          op_r <= op_t'(op);
          an_r <= an; ad_r <= ad; bn_r <= bn; bd_r <= bd;
          st_r <= S_MUL;
        end
        S_MUL: begin
          p0_r <= m0;
          p1_r <= m1;
          st_r <= S_SUM;
        end
        S_SUM: begin
          q_full_r <= 1'b1;
          st_r <= S_IDLE;
          unique case (op_r)
            OP_REDUCE: begin qn_r <= an_r; qd_r <= ad_r; end
            OP_SCALE:  begin qn_r <= p0_r; qd_r <= ad_r; end
            OP_MUL:    begin qn_r <= p0_r; qd_r <= W'(ad_r * bd_r); end
            OP_ADD:    begin qn_r <= p0_r + p1_r; qd_r <= W'(ad_r * bd_r); end
            default:   begin qn_r <= an_r; qd_r <= ad_r; end
          endcase
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // queue is never refilled while still full
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SUM) |-> !q_full_r || q_pop)
    else $error("queue overrun");
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> st_r == S_MUL)
    else $error("accept did not start work");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_MUL) |=> st_r == S_SUM)
    else $error("bad sequence");
endmodule
`default_nettype wire

// ===== hw/rtl/rar_divider.sv =====
// restoring divider, one quotient bit per cycle
// no dependencies
`default_nettype none
module rar_divider #(
  parameter int unsigned W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         go,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quo,
  output logic [W-1:0]      rem
);
  localparam int unsigned CW = $clog2(W + 1);
  logic [CW-1:0] cnt_r;
  logic run_r, done_r;
  logic [W-1:0] q_r, r_r, d_r;
  logic [W:0] sh, diff;

  assign sh = {r_r, q_r[W-1]};
  assign diff = sh - {1'b0, d_r};
  assign done = done_r;
  assign quo = q_r;
  assign rem = r_r;

  // shift-subtract iteration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        q_r <= dividend;
        r_r <= '0;
        d_r <= divisor;
        cnt_r <= CW'(W);
      end else if (run_r) begin
        if (!diff[W]) begin
          r_r <= diff[W-1:0];
          q_r <= {q_r[W-2:0], 1'b1};
        end else begin
          r_r <= sh[W-1:0];
          q_r <= {q_r[W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          run_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/rar_back.sv =====
// back end: euclid gcd and final division, one shared divider
// depends on rar_divider
`default_nettype none
module rar_back #(
  parameter int unsigned W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         q_valid,
  input  wire logic [W-1:0] q_num,
  input  wire logic [W-1:0] q_den,
  output logic              q_pop,
  output logic              out_valid,
  output logic [W-1:0]      out_num,
  output logic [W-1:0]      out_den,
  output logic              out_err
);
  typedef enum logic [2:0] {B_IDLE, B_GCD, B_GWAIT, B_DN, B_DNW, B_DD, B_DDW} st_t;
  st_t st_r;
  logic [W-1:0] n_r, d_r, big_r, lit_r;
  logic go;
  logic [W-1:0] dvd, dvs, quo, rem;
  logic dv_done;
  logic ov_r, oe_r;
  logic [W-1:0] on_r, od_r;

  rar_divider #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .go(go), .dividend(dvd), .divisor(dvs),
    .done(dv_done), .quo(quo), .rem(rem)
  );

  // divider operand selection
  always_comb begin
    go = 1'b0;
    dvd = big_r;
    dvs = lit_r;
    unique case (st_r)
      B_GCD: go = (lit_r != '0);
      B_DN: begin go = 1'b1; dvd = n_r; dvs = big_r; end
      B_DD: begin go = 1'b1; dvd = d_r; dvs = big_r; end
      default: ;
    endcase
  end

  assign q_pop = (st_r == B_IDLE) && q_valid;
  assign out_valid = ov_r;
  assign out_num = on_r;
  assign out_den = od_r;
  assign out_err = oe_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
      ov_r <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      unique case (st_r)
        B_IDLE: if (q_valid) begin
          n_r <= q_num;
          d_r <= q_den;
          big_r <= (q_num > q_den) ? q_num : q_den;
          lit_r <= (q_num > q_den) ? q_den : q_num;
          st_r <= B_GCD;
        end
        B_GCD: begin
          if (lit_r != '0) st_r <= B_GWAIT;
          else if (big_r == '0) begin
            ov_r <= 1'b1; oe_r <= 1'b1; on_r <= '0; od_r <= '0;
            st_r <= B_IDLE;
          end else st_r <= B_DN;
        end
        B_GWAIT: if (dv_done) begin
          big_r <= lit_r;
          lit_r <= rem;
          st_r <= B_GCD;
        end
        B_DN: st_r <= B_DNW;
        B_DNW: if (dv_done) begin on_r <= quo; st_r <= B_DD; end
        B_DD: st_r <= B_DDW;
        B_DDW: if (dv_done) begin
          od_r <= quo; oe_r <= 1'b0; ov_r <= 1'b1;
          st_r <= B_IDLE;
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |=> !ov_r)
    else $error("result strobe longer than one cycle");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && oe_r) |-> (on_r == '0) && (od_r == '0))
    else $error("error result not zero");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_GWAIT) |-> (lit_r != '0))
    else $error("divide by zero");
endmodule
`default_nettype wire
